@@ hdl/tdc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdc_pkg: shared types and constants for the touch dimmer controller
// Register indexes, reset values and the structs passed between modules.
// ----------------------------------------------------------------------------
package tdc_pkg;

	localparam int unsigned CfgIdxW = 3;

	localparam logic [CfgIdxW-1:0] REG_TOUCH_THRESHOLD = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_LONG_PRESS_MS   = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_MIN_PRESS_MS    = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_MAX_BRIGHTNESS  = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_BRIGHTNESS_STEP = 3'd4;

	localparam int unsigned CfgDataW = 31;

	localparam logic [30:0] RST_TOUCH_THRESHOLD = 31'd100;
	localparam logic [15:0] RST_LONG_PRESS_MS   = 16'd2000;
	localparam logic [15:0] RST_MIN_PRESS_MS    = 16'd200;
	localparam logic [7:0]  RST_MAX_BRIGHTNESS  = 8'd255;
	localparam logic [7:0]  RST_BRIGHTNESS_STEP = 8'd5;

	typedef struct packed {
		logic [30:0] touch_threshold;
		logic [15:0] long_press_ms;
		logic [15:0] min_press_ms;
		logic [7:0]  max_brightness;
		logic [7:0]  brightness_step;
	} cfg_t;

	typedef struct packed {
		logic [7:0] pwm_level;
		logic       level_updated;
		logic       lamp_is_on;
	} result_t;

endpackage

@@ hdl/tdc_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdc_regs: configuration register file
// Holds the five settings; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module tdc_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	input  logic [tdc_pkg::CfgIdxW-1:0]     cfg_index,
	input  logic [tdc_pkg::CfgDataW-1:0]    cfg_data,
	output tdc_pkg::cfg_t                   cfg
);

	tdc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.touch_threshold <= tdc_pkg::RST_TOUCH_THRESHOLD;
			cfg_q.long_press_ms   <= tdc_pkg::RST_LONG_PRESS_MS;
			cfg_q.min_press_ms    <= tdc_pkg::RST_MIN_PRESS_MS;
			cfg_q.max_brightness  <= tdc_pkg::RST_MAX_BRIGHTNESS;
			cfg_q.brightness_step <= tdc_pkg::RST_BRIGHTNESS_STEP;
		end else if (cfg_valid) begin
			case (cfg_index)
				tdc_pkg::REG_TOUCH_THRESHOLD: cfg_q.touch_threshold <= cfg_data[30:0];
				tdc_pkg::REG_LONG_PRESS_MS:   cfg_q.long_press_ms   <= cfg_data[15:0];
				tdc_pkg::REG_MIN_PRESS_MS:    cfg_q.min_press_ms    <= cfg_data[15:0];
				tdc_pkg::REG_MAX_BRIGHTNESS:  cfg_q.max_brightness  <= cfg_data[7:0];
				tdc_pkg::REG_BRIGHTNESS_STEP: cfg_q.brightness_step <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ hdl/tdc_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdc_core: touch state and brightness update
// Holds touch/lamp state; computes the next state and result for one sample.
// ----------------------------------------------------------------------------
module tdc_core (
	input  logic                   clk,
	input  logic                   arst_n,
	input  tdc_pkg::cfg_t          cfg,
	input  logic                   step,
	input  logic signed [31:0]     sensor_reading,
	input  logic [31:0]            now_ms,
	output tdc_pkg::result_t       res
);

	logic        touch_held_q;
	logic [31:0] touch_start_q;
	logic [7:0]  level_q;
	logic        lamp_q;

	logic        touched;
	logic [31:0] held_for;
	logic        past_long;
	logic        past_min;
	logic [8:0]  ramp_sum;
	logic        held_n;
	logic [31:0] start_n;
	logic [7:0]  level_n;
	logic        lamp_n;
	logic        updated;

	assign touched   = sensor_reading > $signed({1'b0, cfg.touch_threshold});
	assign held_for  = now_ms - touch_start_q;
	assign past_long = held_for >= {16'd0, cfg.long_press_ms};
	assign past_min  = held_for >= {16'd0, cfg.min_press_ms};
	assign ramp_sum  = {1'b0, level_q} + {1'b0, cfg.brightness_step};

	always_comb begin
		held_n  = touch_held_q;
		start_n = touch_start_q;
		level_n = level_q;
		lamp_n  = lamp_q;
		updated = 1'b0;
		if (touched) begin
			if (!touch_held_q) begin
				start_n = now_ms;
				held_n  = 1'b1;
			end else if (past_long) begin
				lamp_n  = 1'b1;
				updated = 1'b1;
				if (level_q < cfg.max_brightness) begin
					level_n = (ramp_sum > {1'b0, cfg.max_brightness}) ?
						cfg.max_brightness : ramp_sum[7:0];
				end else begin
					level_n = '0;
				end
			end
		end else if (touch_held_q) begin
			held_n = 1'b0;
			if (past_min && !past_long) begin
				if (!lamp_q && level_q == '0) begin
					level_n = cfg.max_brightness;
				end
				lamp_n  = !lamp_q;
				updated = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			touch_held_q  <= 1'b0;
			touch_start_q <= '0;
			level_q       <= '0;
			lamp_q        <= 1'b0;
		end else if (step) begin
			touch_held_q  <= held_n;
			touch_start_q <= start_n;
			level_q       <= level_n;
			lamp_q        <= lamp_n;
		end
	end

	assign res.pwm_level     = lamp_n ? level_n : 8'd0;
	assign res.level_updated = updated;
	assign res.lamp_is_on    = lamp_n;

	// lamp state only moves together with an update flag
	a_lamp_change_flagged: assert property (@(posedge clk) disable iff (!arst_n)
		step && (lamp_n != lamp_q) |-> updated)
		else $error("lamp state changed without update");
	// a touch-start sample never changes the level
	a_start_no_update: assert property (@(posedge clk) disable iff (!arst_n)
		step && touched && !touch_held_q |-> !updated && level_n == level_q)
		else $error("touch start changed the level");

endmodule

@@ hdl/touch_dimmer_controller.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_dimmer_controller: one-button touch lamp dimmer
// Sample register, state update and result register for a touch lamp.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one sensor sample per transfer:
//   sensor_reading (signed) and now_ms (wrapping ms timestamp).
//   Output channel (out_valid/out_stall) returns one result per sample:
//   pwm_level, level_updated, lamp_is_on.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the five
//   settings; cfg_ready is always high. Write only while the block is idle.
// Timing:
//   A sample passes through the input register, then the result register,
//   which is loaded as the touch/lamp state updates. Throughput is one sample
//   per cycle while the output is not stalled.
// Reset:
//   arst_n clears valid and core state: lamp off, level 0, no touch, default settings.
// Stall:
//   When out_stall holds a pending result, the sample register keeps its item
//   and in_stall rises once it is occupied; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module touch_dimmer_controller (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic signed [31:0]              sensor_reading,
	input  logic [31:0]                     now_ms,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [7:0]                      pwm_level,
	output logic                            level_updated,
	output logic                            lamp_is_on,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [tdc_pkg::CfgIdxW-1:0]     cfg_index,
	input  logic [tdc_pkg::CfgDataW-1:0]    cfg_data
);

	tdc_pkg::cfg_t    cfg;
	tdc_pkg::result_t res;
	tdc_pkg::result_t res_s2;

	logic               valid_s1;
	logic signed [31:0] reading_s1;
	logic [31:0]        now_s1;
	logic               valid_s2;
	logic               advance;
	logic               in_xfer;

	assign cfg_ready = 1'b1;

	tdc_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// sample moves into the result register when that register is free
	// or being drained in this cycle
	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_xfer  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			reading_s1 <= sensor_reading;
			now_s1     <= now_ms;
		end
	end

	tdc_core u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.step           (advance),
		.sensor_reading (reading_s1),
		.now_ms         (now_s1),
		.res            (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign out_valid     = valid_s2;
	assign pwm_level     = res_s2.pwm_level;
	assign level_updated = res_s2.level_updated;
	assign lamp_is_on    = res_s2.lamp_is_on;

	// input only backs up when both stages hold items and the output is stalled
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && valid_s2 && out_stall)
		else $error("input stalled without a full pipe");
	// a sample that leaves stage one always shows up as a result
	a_advance_lands: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("advanced sample lost");
	// lamp off always drives the LED dark
	a_off_dark: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !lamp_is_on |-> pwm_level == 8'd0)
		else $error("lamp off with nonzero level");

endmodule
